/* rtl/ps2mct_pkg.sv */
// Shared types and constants for the PS/2 mouse cursor tracker.
package ps2mct_pkg;

  localparam int unsigned PosW  = 12;
  localparam int unsigned ByteW = 8;
  localparam int unsigned BtnW  = 3;
  localparam int unsigned IdxW  = 8;

  localparam int unsigned OutFieldsW = BtnW + 4 * PosW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [PosW-1:0] ResetXLimit = 12'd1272;
  localparam logic [PosW-1:0] ResetYLimit = 12'd712;
  localparam logic [PosW-1:0] ResetPosX   = 12'd640;
  localparam logic [PosW-1:0] ResetPosY   = 12'd360;

  localparam logic [BtnW-1:0] ButtonMask = 3'h7;

  localparam logic [IdxW-1:0] RegXLimit = 8'd0;
  localparam logic [IdxW-1:0] RegYLimit = 8'd1;

  typedef struct packed {
    logic                    done;
    logic [BtnW-1:0]         buttons;
    logic signed [ByteW-1:0] dx;
    logic signed [ByteW-1:0] dy;
  } packet_t;

endpackage

/* rtl/ps2mct_framer.sv */
// Byte phase counter that groups mouse bytes into three-byte packets.
module ps2mct_framer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         beat,
  input  logic [ps2mct_pkg::ByteW-1:0] rx_byte,
  output ps2mct_pkg::packet_t          pkt
);
  import ps2mct_pkg::*;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  phase_t           phase;
  logic [ByteW-1:0] first_byte;
  logic [ByteW-1:0] second_byte;
  logic [ByteW-1:0] neg_byte;

  assign neg_byte    = ByteW'(~rx_byte + 1'b1);
  assign pkt.done    = (phase == PH_THIRD);
  assign pkt.buttons = first_byte[BtnW-1:0] & ButtonMask;
  assign pkt.dx      = second_byte;
  assign pkt.dy      = neg_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FIRST;
      first_byte  <= '0;
      second_byte <= '0;
    end else if (beat) begin
      case (phase)
        PH_SECOND: begin
          second_byte <= rx_byte;
          phase       <= PH_THIRD;
        end
        PH_THIRD: begin
          phase <= PH_FIRST;
        end
        default: begin
          first_byte <= rx_byte;
          phase      <= PH_SECOND;
        end
      endcase
    end
  end

endmodule

/* rtl/ps2mct_axis.sv */
// One cursor axis: add a signed step and clamp to zero and the limit.
module ps2mct_axis (
  input  logic [ps2mct_pkg::PosW-1:0]         pos,
  input  logic signed [ps2mct_pkg::ByteW-1:0] step,
  input  logic [ps2mct_pkg::PosW-1:0]         limit,
  output logic [ps2mct_pkg::PosW-1:0]         pos_next
);
  import ps2mct_pkg::*;

  localparam int unsigned SumW = PosW + 2;

  logic [SumW-1:0] sum;

  assign sum = {2'b00, pos} + {{(SumW-ByteW){step[ByteW-1]}}, step};

  always_comb begin
    if (sum[SumW-1]) begin
      pos_next = '0;
    end else if (sum[SumW-2:0] > {1'b0, limit}) begin
      pos_next = limit;
    end else begin
      pos_next = sum[PosW-1:0];
    end
  end

endmodule

/* rtl/ps2_mouse_cursor_tracker_core.sv */
// Top level of the PS/2 mouse cursor tracker.
//
// Mouse bytes arrive on the s_axis channel, one byte per beat. Every third
// accepted byte closes a packet: byte 0 gives the buttons, byte 1 the x step,
// byte 2 the y step (negated). The cursor moves by both steps, each axis
// clamped to zero and its limit, and one beat leaves on m_axis with the
// buttons, the new position and the position before the packet.
// Latency: the result is registered and shows on m_axis the cycle after the
// third byte is accepted. Throughput: one byte per cycle while m_axis drains;
// the single result register sets that figure.
// A byte is taken whenever the result register is empty or is being emptied
// in the same cycle; while m_axis stalls with a result pending, s_axis_tready
// stays low.
// The cfg channel writes x_limit (index 0) and y_limit (index 1); other
// indexes are ignored. cfg_ready is always high.
// Reset: byte phase returns to the first byte, the cursor to 640/360, the
// limits to 1272/712, and the result register empties.
module ps2_mouse_cursor_tracker_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ps2mct_pkg::ByteW-1:0]      s_axis_tdata,   // rx_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // button_bits[2:0], cursor_x[14:3], cursor_y[26:15], old_x[38:27], old_y[50:39]
  output logic [ps2mct_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ps2mct_pkg::IdxW-1:0]       cfg_index,
  input  logic [ps2mct_pkg::PosW-1:0]       cfg_data
);
  import ps2mct_pkg::*;

  logic            in_beat;
  packet_t         pkt;
  logic            load;

  logic [PosW-1:0] x_limit;
  logic [PosW-1:0] y_limit;
  logic [PosW-1:0] pos_x;
  logic [PosW-1:0] pos_y;
  logic [PosW-1:0] pos_x_next;
  logic [PosW-1:0] pos_y_next;

  logic [BtnW-1:0] out_buttons;
  logic [PosW-1:0] out_x;
  logic [PosW-1:0] out_y;
  logic [PosW-1:0] out_old_x;
  logic [PosW-1:0] out_old_y;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign load          = in_beat && pkt.done;
  assign cfg_ready     = 1'b1;

  ps2mct_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .beat    (in_beat),
    .rx_byte (s_axis_tdata),
    .pkt     (pkt)
  );

  ps2mct_axis u_axis_x (
    .pos      (pos_x),
    .step     (pkt.dx),
    .limit    (x_limit),
    .pos_next (pos_x_next)
  );

  ps2mct_axis u_axis_y (
    .pos      (pos_y),
    .step     (pkt.dy),
    .limit    (y_limit),
    .pos_next (pos_y_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit <= ResetXLimit;
      y_limit <= ResetYLimit;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegXLimit: x_limit <= cfg_data;
        RegYLimit: y_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x         <= ResetPosX;
      pos_y         <= ResetPosY;
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      pos_x         <= pos_x_next;
      pos_y         <= pos_y_next;
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_buttons <= pkt.buttons;
      out_x       <= pos_x_next;
      out_y       <= pos_y_next;
      out_old_x   <= pos_x;
      out_old_y   <= pos_y;
    end
  end

  assign m_axis_tdata = {{(OutDataW-OutFieldsW){1'b0}},
                         out_old_y, out_old_x, out_y, out_x, out_buttons};

  a_rise_on_packet: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(load))
    else $error("result appeared without a closing byte");

  a_load_tracks_pos: assert property (@(posedge clk) disable iff (rst)
    load |=> m_axis_tvalid && out_x == pos_x && out_y == pos_y)
    else $error("result position differs from cursor state");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !load |=> !m_axis_tvalid)
    else $error("result repeated after being taken");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("byte taken while result is stalled");

endmodule
